// ===== rtl/core/steq_pkg.sv =====
// Shared types and constants for the sorted timer event queue.
package steq_pkg;

    localparam int TIME_BITS      = 48;
    localparam int SLOT_BITS      = 4;
    localparam int TICK_LEN_BITS  = 24;
    localparam int NUM_CLOCKS_DEF = 16;

    localparam logic [TICK_LEN_BITS-1:0] TICK_LEN_RESET = 24'd20480;
    localparam logic [TIME_BITS-1:0]     TIME_MAX       = {TIME_BITS{1'b1}};

    // Request codes on the input channel
    typedef enum logic [1:0] {
        OP_ARM_ABS   = 2'd0,
        OP_ARM_DELAY = 2'd1,
        OP_DISARM    = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    // One input beat
    typedef struct packed {
        op_t                  opcode;
        logic [SLOT_BITS-1:0] clock_id;
        logic [TIME_BITS-1:0] time_value;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        logic                 clock_fired;
        logic [SLOT_BITS-1:0] fired_clock;
        logic [TIME_BITS-1:0] event_time;
        logic                 last;
    } out_beat_t;

    // One queue row held by a cell
    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] deadline;
        logic [SLOT_BITS-1:0] slot;
    } entry_t;

    // Row-wide operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_REMOVE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] when;
    } cell_cmd_t;

endpackage

// ===== rtl/core/steq_cell.sv =====
// One queue cell: holds a row and shifts with its neighbors on remove, insert and pop.
module steq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  steq_pkg::cell_cmd_t cmd,
    input  steq_pkg::entry_t    left_entry,
    input  logic                left_ge,
    input  logic                left_hit,
    input  steq_pkg::entry_t    right_entry,
    output steq_pkg::entry_t    entry,
    output logic                ge,
    output logic                hit
);

    steq_pkg::entry_t entry_reg;
    steq_pkg::entry_t entry_next;
    logic             match;

    // Flag a matching slot and rows that stay ahead of a new deadline
    assign match = entry_reg.valid && (entry_reg.slot == cmd.slot);
    assign hit   = left_hit || match;
    assign ge    = entry_reg.valid && (entry_reg.deadline <= cmd.when);
    assign entry = entry_reg;

    // Pick the next row content
    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            steq_pkg::CELL_REMOVE: begin
                if (hit) begin
                    entry_next = right_entry;
                end
            end
            steq_pkg::CELL_INSERT: begin
                if (!ge) begin
                    if (left_ge) begin
                        entry_next.valid    = 1'b1;
                        entry_next.deadline = cmd.when;
                        entry_next.slot     = cmd.slot;
                    end else begin
                        entry_next = left_entry;
                    end
                end
            end
            steq_pkg::CELL_POP: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the row; only the valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.deadline <= entry_next.deadline;
        entry_reg.slot     <= entry_next.slot;
    end

endmodule

// ===== rtl/core/sorted_timer_event_queue.sv =====
// Top level of the sorted timer event queue: request control, logical time and cell row.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  s_       | in        | s_valid / s_ready  | s_data  (in_beat_t)
//  m_       | out       | m_valid / m_ready  | m_data  (out_beat_t)
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data (tick length)
//
// An arm runs accept, remove pass, insert pass and result; a disarm skips the insert
// pass, and a bad slot goes straight to the result. A tick gives one beat per firing and a
// closing beat; the head cell is compared and popped once per cycle, as the output register frees up.
// Reset is synchronous and empties the row at once; no clearing pass.
// A stalled result holds the sequencer; s_ready is high only when idle.
module sorted_timer_event_queue #(
    parameter int NUM_CLOCKS = steq_pkg::NUM_CLOCKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  steq_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output steq_pkg::out_beat_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [steq_pkg::TICK_LEN_BITS-1:0]  cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_DONE,
        ST_TICK
    } state_t;

    state_t                               state_reg, state_next;
    steq_pkg::op_t                        op_reg, op_next;
    logic [steq_pkg::SLOT_BITS-1:0]       slot_reg, slot_next;
    logic [steq_pkg::TIME_BITS-1:0]       arg_reg, arg_next;
    logic [steq_pkg::TIME_BITS-1:0]       lt_reg, lt_next;
    logic [steq_pkg::TICK_LEN_BITS-1:0]   tick_len_reg, tick_len_next;
    logic                                 m_valid_reg, m_valid_next;
    steq_pkg::out_beat_t                  m_data_reg, m_data_next;

    steq_pkg::cell_cmd_t                  cmd;
    steq_pkg::entry_t                     cell_entry [NUM_CLOCKS];
    logic                                 cell_ge    [NUM_CLOCKS];
    logic                                 cell_hit   [NUM_CLOCKS];

    logic                                 accept;
    logic                                 out_free;
    logic                                 slot_ok;
    logic                                 queue_full;
    logic                                 head_due;
    logic [steq_pkg::TIME_BITS:0]         delay_sum;
    logic [steq_pkg::TIME_BITS:0]         tick_sum;
    logic [steq_pkg::TIME_BITS-1:0]       abs_when;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign slot_ok    = int'(s_data.clock_id) < NUM_CLOCKS;
    assign queue_full = cell_entry[NUM_CLOCKS-1].valid;
    assign head_due   = cell_entry[0].valid && (cell_entry[0].deadline < arg_reg);

    // Clamp and saturate request times
    assign abs_when  = (s_data.time_value < lt_reg) ? lt_reg : s_data.time_value;
    assign delay_sum = {1'b0, lt_reg} + {1'b0, s_data.time_value};
    assign tick_sum  = {1'b0, lt_reg}
                     + {{(steq_pkg::TIME_BITS + 1 - steq_pkg::TICK_LEN_BITS){1'b0}},
                        tick_len_reg};

    // Broadcast the row operation
    always_comb begin
        cmd.slot = slot_reg;
        cmd.when = arg_reg;
        cmd.op   = steq_pkg::CELL_HOLD;
        case (state_reg)
            ST_REMOVE: cmd.op = steq_pkg::CELL_REMOVE;
            ST_INSERT: cmd.op = queue_full ? steq_pkg::CELL_HOLD : steq_pkg::CELL_INSERT;
            ST_TICK:   cmd.op = (out_free && head_due) ? steq_pkg::CELL_POP
                                                       : steq_pkg::CELL_HOLD;
            default:   cmd.op = steq_pkg::CELL_HOLD;
        endcase
    end

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < NUM_CLOCKS; i++) begin : g_cell
        steq_pkg::entry_t left_entry;
        steq_pkg::entry_t right_entry;
        logic             left_ge;
        logic             left_hit;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_ge    = 1'b1;
            assign left_hit   = 1'b0;
        end else begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_ge    = cell_ge[i-1];
            assign left_hit   = cell_hit[i-1];
        end

        if (i == NUM_CLOCKS - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        steq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_ge     (left_ge),
            .left_hit    (left_hit),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i]),
            .hit         (cell_hit[i])
        );
    end

    // Sequence requests and build result beats
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        arg_next      = arg_reg;
        lt_next       = lt_reg;
        tick_len_next = tick_len_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cfg_wr_en) begin
            tick_len_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next   = s_data.opcode;
                    slot_next = s_data.clock_id;
                    case (s_data.opcode)
                        steq_pkg::OP_ARM_ABS: begin
                            arg_next   = abs_when;
                            state_next = slot_ok ? ST_REMOVE : ST_DONE;
                        end
                        steq_pkg::OP_ARM_DELAY: begin
                            arg_next   = delay_sum[steq_pkg::TIME_BITS]
                                       ? steq_pkg::TIME_MAX
                                       : delay_sum[steq_pkg::TIME_BITS-1:0];
                            state_next = slot_ok ? ST_REMOVE : ST_DONE;
                        end
                        steq_pkg::OP_DISARM: begin
                            state_next = slot_ok ? ST_REMOVE : ST_DONE;
                        end
                        default: begin
                            arg_next   = tick_sum[steq_pkg::TIME_BITS]
                                       ? steq_pkg::TIME_MAX
                                       : tick_sum[steq_pkg::TIME_BITS-1:0];
                            state_next = ST_TICK;
                        end
                    endcase
                end
            end
            ST_REMOVE: begin
                state_next = (op_reg == steq_pkg::OP_DISARM) ? ST_DONE : ST_INSERT;
            end
            ST_INSERT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.clock_fired = 1'b0;
                    m_data_next.fired_clock = '0;
                    m_data_next.event_time  = lt_reg;
                    m_data_next.last        = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (head_due) begin
                        // fire the head and advance time to its deadline
                        lt_next                 = cell_entry[0].deadline;
                        m_data_next.clock_fired = 1'b1;
                        m_data_next.fired_clock = cell_entry[0].slot;
                        m_data_next.event_time  = cell_entry[0].deadline;
                        m_data_next.last        = 1'b0;
                    end else begin
                        // close the tick at its end time
                        lt_next                 = arg_reg;
                        m_data_next.clock_fired = 1'b0;
                        m_data_next.fired_clock = '0;
                        m_data_next.event_time  = arg_reg;
                        m_data_next.last        = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, time, register and output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lt_reg       <= '0;
            tick_len_reg <= steq_pkg::TICK_LEN_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lt_reg       <= lt_next;
            tick_len_reg <= tick_len_next;
            m_valid_reg  <= m_valid_next;
        end
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        arg_reg    <= arg_next;
        m_data_reg <= m_data_next;
    end

endmodule
